// ----- rtl/owst_pkg.sv -----
// Shared types, codes and reset values for the 1-Wire master slot timer.
package owst_pkg;

    localparam int OP_W          = 2;
    localparam int DATA_W        = 8;
    localparam int STATUS_W      = 2;
    localparam int CFG_W         = 12;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 5;
    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);

    localparam int TIMER_WIDTH_DEF    = 12;
    localparam int READ_TAIL_TIME_DEF = 45;

    // Opcodes carried by a tick
    localparam logic [OP_W-1:0] OP_NONE  = 2'd0;
    localparam logic [OP_W-1:0] OP_RESET = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd2;
    localparam logic [OP_W-1:0] OP_READ  = 2'd3;

    // Completion and tick status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LINE_BUSY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_PRESENCE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED     = 2'd3;

    typedef struct packed {
        logic [CFG_W-1:0] reset_low_time;
        logic [CFG_W-1:0] presence_wait_time;
        logic [CFG_W-1:0] one_low_time;
        logic [CFG_W-1:0] one_high_time;
        logic [CFG_W-1:0] zero_low_time;
        logic [CFG_W-1:0] zero_high_time;
        logic [CFG_W-1:0] read_low_time;
        logic [CFG_W-1:0] read_sample_delay;
    } cfg_regs_t;

    localparam cfg_regs_t CFG_RESET = '{
        reset_low_time:     12'd480,
        presence_wait_time: 12'd70,
        one_low_time:       12'd10,
        one_high_time:      12'd55,
        zero_low_time:      12'd65,
        zero_high_time:     12'd5,
        read_low_time:      12'd3,
        read_sample_delay:  12'd10
    };

endpackage

// ----- rtl/owst_tick_if.sv -----
// Input channel: one bus tick with optional command.
interface owst_tick_if;
    import owst_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [DATA_W-1:0] data_byte;
    logic              line_level;

    modport source (output valid, output opcode, output data_byte, output line_level,
                    input ready);
    modport sink   (input valid, input opcode, input data_byte, input line_level,
                    output ready);
endinterface

// ----- rtl/owst_result_if.sv -----
// Output channel: one result per tick.
interface owst_result_if;
    import owst_pkg::*;

    logic                valid;
    logic                ready;
    logic                drive_low;
    logic                busy_res;
    logic                done_res;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   read_data;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output status, output read_data, input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input status, input read_data, output ready);
endinterface

// ----- rtl/onewire_master_slot_timer_unit.sv -----
// Top level of the 1-Wire bus master slot timer.
//
// Usage:
//   tick   : one transfer per bus microsecond, carrying the sampled line
//            level and an optional command (reset/presence, write byte,
//            read byte) with the byte to write.
//   result : one transfer per accepted tick with drive_low for that tick,
//            busy, done, status and the read byte on a read completion.
//   APB    : eight 12-bit timing registers at byte addresses 4*i; writes
//            complete in the access cycle, pready is tied high. Write
//            them only while no command is running.
// The result is registered and valid in the cycle after the tick transfer.
// One tick is accepted every cycle unless the receiver stalls; the state
// update and result formation fit in one sequencer pass between the tick
// and the result register. If the receiver stalls, the pending result holds
// and tick.ready stays low until it is taken; a new tick is accepted in the
// same cycle a held result leaves. Reset returns the sequencer to idle,
// empties the result register and loads the default timing values.
module onewire_master_slot_timer_unit
#(
    parameter int TIMER_WIDTH    = owst_pkg::TIMER_WIDTH_DEF,
    parameter int READ_TAIL_TIME = owst_pkg::READ_TAIL_TIME_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    owst_tick_if.sink                       tick,
    owst_result_if.source                   result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [owst_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [owst_pkg::APB_DATA_W-1:0] pwdata,
    output logic [owst_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import owst_pkg::*;

    cfg_regs_t cfg;

    owst_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    owst_core
    #(
        .TIMER_WIDTH    (TIMER_WIDTH),
        .READ_TAIL_TIME (READ_TAIL_TIME)
    )
    u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .tick   (tick),
        .result (result)
    );

endmodule

// ----- rtl/owst_cfg.sv -----
// APB register file holding the slot timing configuration.
module owst_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [owst_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [owst_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [owst_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output owst_pkg::cfg_regs_t                 cfg
);
    import owst_pkg::*;

    localparam logic [2:0] REG_RESET_LOW    = 3'd0;
    localparam logic [2:0] REG_PRESENCE     = 3'd1;
    localparam logic [2:0] REG_ONE_LOW      = 3'd2;
    localparam logic [2:0] REG_ONE_HIGH     = 3'd3;
    localparam logic [2:0] REG_ZERO_LOW     = 3'd4;
    localparam logic [2:0] REG_ZERO_HIGH    = 3'd5;
    localparam logic [2:0] REG_READ_LOW     = 3'd6;
    localparam logic [2:0] REG_SAMPLE_DELAY = 3'd7;

    cfg_regs_t        cfg_reg;
    cfg_regs_t        cfg_next;
    logic [2:0]       reg_idx;
    logic [CFG_W-1:0] wr_val;
    logic [CFG_W-1:0] rd_val;
    logic             wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_val  = pwdata[CFG_W-1:0];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_RESET_LOW:    cfg_next.reset_low_time     = wr_val;
                REG_PRESENCE:     cfg_next.presence_wait_time = wr_val;
                REG_ONE_LOW:      cfg_next.one_low_time       = wr_val;
                REG_ONE_HIGH:     cfg_next.one_high_time      = wr_val;
                REG_ZERO_LOW:     cfg_next.zero_low_time      = wr_val;
                REG_ZERO_HIGH:    cfg_next.zero_high_time     = wr_val;
                REG_READ_LOW:     cfg_next.read_low_time      = wr_val;
                REG_SAMPLE_DELAY: cfg_next.read_sample_delay  = wr_val;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_RESET_LOW:    rd_val = cfg_reg.reset_low_time;
            REG_PRESENCE:     rd_val = cfg_reg.presence_wait_time;
            REG_ONE_LOW:      rd_val = cfg_reg.one_low_time;
            REG_ONE_HIGH:     rd_val = cfg_reg.one_high_time;
            REG_ZERO_LOW:     rd_val = cfg_reg.zero_low_time;
            REG_ZERO_HIGH:    rd_val = cfg_reg.zero_high_time;
            REG_READ_LOW:     rd_val = cfg_reg.read_low_time;
            REG_SAMPLE_DELAY: rd_val = cfg_reg.read_sample_delay;
            default:          rd_val = '0;
        endcase
    end

    assign prdata = APB_DATA_W'(rd_val);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/owst_core.sv -----
// Per-tick sequencer for reset, write and read slots, with the result register.
module owst_core
#(
    parameter int TIMER_WIDTH    = owst_pkg::TIMER_WIDTH_DEF,
    parameter int READ_TAIL_TIME = owst_pkg::READ_TAIL_TIME_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  owst_pkg::cfg_regs_t  cfg,
    owst_tick_if.sink            tick,
    owst_result_if.source        result
);
    import owst_pkg::*;

    localparam int TW = TIMER_WIDTH;
    localparam int TAIL_MOD = READ_TAIL_TIME % (2 ** TW);
    localparam logic [TW-1:0] TAIL_LEN = (TAIL_MOD == 0) ? TW'(1) : TW'(TAIL_MOD);
    localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(BITS_PER_BYTE - 1);

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_RST_LOW   = 4'd1;
    localparam logic [3:0] PH_RST_WAIT1 = 4'd2;
    localparam logic [3:0] PH_RST_WAIT2 = 4'd3;
    localparam logic [3:0] PH_WR_LOW    = 4'd4;
    localparam logic [3:0] PH_WR_HIGH   = 4'd5;
    localparam logic [3:0] PH_RD_LOW    = 4'd6;
    localparam logic [3:0] PH_RD_DELAY  = 4'd7;
    localparam logic [3:0] PH_RD_TAIL   = 4'd8;

    typedef struct packed {
        logic [3:0]    phase;
        logic [TW-1:0] timer;
    } slot_start_t;

    // Register value reduced to the timer width
    function automatic logic [TW-1:0] wrap_len(input logic [CFG_W-1:0] v);
        logic [TW+CFG_W-1:0] wide;
        wide = {{TW{1'b0}}, v};
        return wide[TW-1:0];
    endfunction

    // Required time: zero acts as one
    function automatic logic [TW-1:0] need_len(input logic [CFG_W-1:0] v);
        logic [TW-1:0] t;
        t = wrap_len(v);
        return (t == '0) ? TW'(1) : t;
    endfunction

    function automatic slot_start_t bit_start(input logic [OP_W-1:0]      cmd,
                                              input logic [DATA_W-1:0]    shift_v,
                                              input logic [BIT_IDX_W-1:0] idx,
                                              input cfg_regs_t            c);
        slot_start_t s;
        if (cmd == OP_WRITE)
        begin
            s.phase = PH_WR_LOW;
            s.timer = need_len(shift_v[idx] ? c.one_low_time : c.zero_low_time);
        end
        else
        begin
            s.phase = PH_RD_LOW;
            s.timer = need_len(c.read_low_time);
        end
        return s;
    endfunction

    logic [3:0]           phase_reg,    phase_next;
    logic [TW-1:0]        slot_timer_reg, slot_timer_next;
    logic [BIT_IDX_W-1:0] bit_index_reg, bit_index_next;
    logic [DATA_W-1:0]    shift_byte_reg, shift_byte_next;
    logic [OP_W-1:0]      active_cmd_reg, active_cmd_next;
    logic                 presence_reg, presence_next;
    logic                 sample_due_reg, sample_due_next;

    logic                 res_valid_reg;
    logic                 drive_reg, drive_next;
    logic                 busy_reg;
    logic                 done_reg, done_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [DATA_W-1:0]    rdata_reg, rdata_next;

    logic                 accept;
    logic                 ignored;
    logic                 step_bit;
    logic [STATUS_W-1:0]  fin_status;
    logic [TW-1:0]        hold_t;
    slot_start_t          start;

    assign tick.ready = !res_valid_reg || result.ready;
    assign accept     = tick.valid && tick.ready;

    always_comb
    begin
        phase_next      = phase_reg;
        slot_timer_next = slot_timer_reg;
        bit_index_next  = bit_index_reg;
        shift_byte_next = shift_byte_reg;
        active_cmd_next = active_cmd_reg;
        presence_next   = presence_reg;
        sample_due_next = sample_due_reg;
        done_next       = 1'b0;
        fin_status      = ST_OK;
        ignored         = 1'b0;
        drive_next      = 1'b0;
        step_bit        = 1'b0;
        hold_t          = '0;
        start           = '0;

        if (phase_reg == PH_IDLE)
        begin
            if (tick.opcode != OP_NONE)
            begin
                active_cmd_next = tick.opcode;
                bit_index_next  = '0;
                sample_due_next = 1'b0;
                if (tick.opcode == OP_RESET)
                begin
                    presence_next = 1'b0;
                    if (!tick.line_level)
                    begin
                        // line held low by someone else: finish at once
                        slot_timer_next = '0;
                        done_next       = 1'b1;
                        fin_status      = ST_LINE_BUSY;
                    end
                    else
                    begin
                        phase_next      = PH_RST_LOW;
                        slot_timer_next = need_len(cfg.reset_low_time);
                    end
                end
                else
                begin
                    shift_byte_next = (tick.opcode == OP_WRITE) ? tick.data_byte : '0;
                    start           = bit_start(tick.opcode, shift_byte_next, '0, cfg);
                    phase_next      = start.phase;
                    slot_timer_next = start.timer;
                end
            end
        end
        else if (tick.opcode != OP_NONE)
        begin
            ignored = 1'b1;
        end

        if (phase_next != PH_IDLE)
        begin
            drive_next = (phase_next == PH_RST_LOW) || (phase_next == PH_WR_LOW)
                      || (phase_next == PH_RD_LOW);
            if (sample_due_next)
            begin
                if (phase_next == PH_RST_WAIT2)
                begin
                    presence_next = !tick.line_level;
                end
                else if (phase_next == PH_RD_TAIL)
                begin
                    shift_byte_next[bit_index_next] = shift_byte_next[bit_index_next]
                                                    | tick.line_level;
                end
                sample_due_next = 1'b0;
            end
            slot_timer_next = slot_timer_next - TW'(1);
            if (slot_timer_next == '0)
            begin
                case (phase_next)
                    PH_RST_LOW:
                    begin
                        phase_next      = PH_RST_WAIT1;
                        slot_timer_next = need_len(cfg.presence_wait_time);
                    end
                    PH_RST_WAIT1:
                    begin
                        phase_next      = PH_RST_WAIT2;
                        slot_timer_next = need_len(cfg.presence_wait_time);
                        sample_due_next = 1'b1;
                    end
                    PH_RST_WAIT2:
                    begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                        fin_status = presence_next ? ST_OK : ST_NO_PRESENCE;
                    end
                    PH_WR_LOW:
                    begin
                        hold_t = wrap_len(shift_byte_next[bit_index_next] ?
                                          cfg.one_high_time : cfg.zero_high_time);
                        if (hold_t != '0)
                        begin
                            phase_next      = PH_WR_HIGH;
                            slot_timer_next = hold_t;
                        end
                        else
                        begin
                            step_bit = 1'b1;
                        end
                    end
                    PH_WR_HIGH:
                    begin
                        step_bit = 1'b1;
                    end
                    PH_RD_LOW:
                    begin
                        hold_t = wrap_len(cfg.read_sample_delay);
                        if (hold_t != '0)
                        begin
                            phase_next      = PH_RD_DELAY;
                            slot_timer_next = hold_t;
                        end
                        else
                        begin
                            phase_next      = PH_RD_TAIL;
                            slot_timer_next = TAIL_LEN;
                            sample_due_next = 1'b1;
                        end
                    end
                    PH_RD_DELAY:
                    begin
                        phase_next      = PH_RD_TAIL;
                        slot_timer_next = TAIL_LEN;
                        sample_due_next = 1'b1;
                    end
                    PH_RD_TAIL:
                    begin
                        step_bit = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                endcase

                // advance to the next bit slot or close the byte
                if (step_bit)
                begin
                    if (bit_index_next == LAST_BIT)
                    begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        bit_index_next  = bit_index_next + BIT_IDX_W'(1);
                        start           = bit_start(active_cmd_next, shift_byte_next,
                                                    bit_index_next, cfg);
                        phase_next      = start.phase;
                        slot_timer_next = start.timer;
                    end
                end

                if (phase_next == PH_IDLE)
                begin
                    slot_timer_next = '0;
                end
            end
        end

        if (done_next)
        begin
            status_next = fin_status;
        end
        else if (ignored)
        begin
            status_next = ST_IGNORED;
        end
        else
        begin
            status_next = ST_OK;
        end
        rdata_next = (done_next && (active_cmd_next == OP_READ)) ? shift_byte_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            slot_timer_reg <= '0;
            bit_index_reg  <= '0;
            shift_byte_reg <= '0;
            active_cmd_reg <= OP_NONE;
            presence_reg   <= 1'b0;
            sample_due_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg      <= phase_next;
                slot_timer_reg <= slot_timer_next;
                bit_index_reg  <= bit_index_next;
                shift_byte_reg <= shift_byte_next;
                active_cmd_reg <= active_cmd_next;
                presence_reg   <= presence_next;
                sample_due_reg <= sample_due_next;
                res_valid_reg  <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            drive_reg  <= drive_next;
            busy_reg   <= (phase_next != PH_IDLE);
            done_reg   <= done_next;
            status_reg <= status_next;
            rdata_reg  <= rdata_next;
        end
    end

    assign result.valid     = res_valid_reg;
    assign result.drive_low = drive_reg;
    assign result.busy_res  = busy_reg;
    assign result.done_res  = done_reg;
    assign result.status    = status_reg;
    assign result.read_data = rdata_reg;

`ifndef SYNTH
    a_idle_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (slot_timer_reg == '0))
        else $error("slot timer not cleared while idle");

    a_active_timer_live: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (slot_timer_reg != '0))
        else $error("slot timer expired without a phase change");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && done_reg) |-> !busy_reg)
        else $error("completion reported while still busy");

    a_rdata_only_on_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (rdata_reg != '0)) |-> (done_reg && (active_cmd_reg == OP_READ)))
        else $error("read data shown outside a read completion");

    a_idle_after_busy_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (phase_next == PH_IDLE)) |=> (phase_reg == PH_IDLE && !busy_reg))
        else $error("busy flag out of step with phase");
`endif

endmodule
